// ----- src/jbpr_pkg.sv -----
// Shared types and constants of the playout release block.
package jbpr_pkg;

   localparam int unsigned MsPerSec = 1000;

   typedef enum logic [1:0] {
      REQ_PUSH_VIDEO = 2'd0,
      REQ_PUSH_AUDIO = 2'd1,
      REQ_TICK       = 2'd2,
      REQ_UNUSED     = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_RELEASED = 2'd0,
      ST_ACCEPTED = 2'd1,
      ST_DROPPED  = 2'd2,
      ST_NONE     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_AUTO_MODE = 2'd0,
      REG_CACHE_SEC = 2'd1,
      REG_MIN_SEC   = 2'd2,
      REG_NONE      = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_CACHE,
      BK_DRAIN_V,
      BK_DRAIN_A
   } back_state_type;

   // request word as queued between front and back
   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  pkt_kind;
      logic [15:0] pkt_handle;
      logic [15:0] pkt_length;
      logic [31:0] decode_stamp;
      logic [31:0] present_stamp;
      logic [31:0] now_ms;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        out_stream;
      logic [7:0]  out_kind;
      logic [15:0] out_handle;
      logic [15:0] out_length;
      logic [31:0] out_present_stamp;
      logic        playing;
      logic        last;
   } rsp_word_type;

endpackage

// ----- src/jbpr_if.sv -----
// Valid/ready channel interfaces for requests, results and register writes.
interface jbpr_req_if;
   logic valid;
   logic ready;
   jbpr_pkg::req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface jbpr_rsp_if;
   logic valid;
   logic ready;
   jbpr_pkg::rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface jbpr_csr_if;
   logic valid;
   logic ready;
   logic [1:0]  index;
   logic [15:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- src/jitter_buffer_playout_release.sv -----
// Top level of the jitter buffer playout release block.
//
// Requests enter on req (push video, push audio, tick); each request gives
// one or more result words on rsp, the final one flagged by last. csr writes
// set auto_mode, cache_seconds and min_cache_seconds; write them while idle.
// A push's result is registered in the result slot as the push is taken; a
// caching tick steps through head read, tail read, then span compare and
// result. A playing tick releases one due packet per cycle while rsp is ready;
// each released word is parked one step so the final one can carry last, and
// each stream's scan ends at its first packet that is not yet due.
// The front end holds two request words, so pushes are taken while the
// back end works; one item is handled at a time. Reset empties both
// queues, returns to caching and restores the register defaults; RAM
// contents are left as they are. A stalled rsp receiver holds the back
// end, and once the front end is full req.ready drops.
module jitter_buffer_playout_release #(
   parameter int unsigned QUEUE_DEPTH = 32
) (
   input logic clock,
   input logic reset,
   jbpr_req_if.sink   req,
   jbpr_rsp_if.source rsp,
   jbpr_csr_if.sink   csr
);
   logic        auto_mode_ff;
   logic [15:0] cache_sec_ff, min_sec_ff;
   logic        q_valid, q_pop;
   jbpr_pkg::req_word_type q_word;

   assign csr.ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         auto_mode_ff <= 1'b0;
         cache_sec_ff <= 16'd1;
         min_sec_ff   <= 16'd1;
      end else if (csr.valid) begin
         unique case (jbpr_pkg::reg_index_type'(csr.index))
            jbpr_pkg::REG_AUTO_MODE: auto_mode_ff <= csr.wdata[0];
            jbpr_pkg::REG_CACHE_SEC: cache_sec_ff <= csr.wdata;
            jbpr_pkg::REG_MIN_SEC:   min_sec_ff   <= csr.wdata;
            default: ;
         endcase
      end
   end

   jbpr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .in_word  (req.data),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_word   (q_word)
   );

   jbpr_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_word            (q_word),
      .auto_mode         (auto_mode_ff),
      .cache_seconds     (cache_sec_ff),
      .min_cache_seconds (min_sec_ff),
      .out_valid         (rsp.valid),
      .out_ready         (rsp.ready),
      .out_word          (rsp.data)
   );
endmodule

// ----- src/jbpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module jbpr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- src/jbpr_front.sv -----
// Front end: two-entry request queue between the input port and the back end.
module jbpr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  jbpr_pkg::req_word_type in_word,
   output logic                  q_valid,
   input  logic                  q_pop,
   output jbpr_pkg::req_word_type q_word
);
   jbpr_pkg::req_word_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_word   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_word;
      end
   end
endmodule

// ----- src/jbpr_back.sv -----
// Back end: descriptor queues, caching test and release sequencer.
module jbpr_back #(
   parameter int unsigned QUEUE_DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  jbpr_pkg::req_word_type q_word,
   input  logic                   auto_mode,
   input  logic [15:0]            cache_seconds,
   input  logic [15:0]            min_cache_seconds,
   output logic                   out_valid,
   input  logic                   out_ready,
   output jbpr_pkg::rsp_word_type out_word
);
   localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned EW = 32 + 32 + 40;

   jbpr_pkg::back_state_type state_ff, state_in;
   logic [AW-1:0] head_ff [2];
   logic [AW-1:0] head_in [2];
   logic [CW-1:0] cnt_ff [2];
   logic [CW-1:0] cnt_in [2];
   logic          play_ff, play_in;
   logic [31:0]   org_data_ff, org_data_in, org_sys_ff, org_sys_in;
   logic [31:0]   dtime_ff, dtime_in;
   logic          out_valid_ff, out_valid_in;
   jbpr_pkg::rsp_word_type out_ff, out_in;
   logic [31:0]   thr_ff, thr_in;
   // released word parked until the next due test tells whether it is last
   logic          hold_valid_ff, hold_valid_in;
   jbpr_pkg::rsp_word_type hold_ff, hold_in;

   // RAM ports, one RAM per stream; reads addressed by head or tail
   logic          wr_en [2];
   logic [AW-1:0] wr_addr [2];
   logic [EW-1:0] wr_data;
   logic [AW-1:0] rd_addr [2];
   logic [EW-1:0] rd_data [2];
   logic [EW-1:0] first_ff [2];
   logic [EW-1:0] first_in [2];
   logic          sel_tail_ff, sel_tail_in;

   function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
      logic [AW:0] r;
      r = (v >= (AW+1)'(QUEUE_DEPTH)) ? v - (AW+1)'(QUEUE_DEPTH) : v;
      return r[AW-1:0];
   endfunction

   assign wr_data = {q_word.decode_stamp, q_word.present_stamp,
                     q_word.pkt_kind, q_word.pkt_handle, q_word.pkt_length};

   for (genvar g = 0; g < 2; g++) begin : g_q
      jbpr_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (wr_addr[g]),
         .wr_data (wr_data),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_data[g])
      );
      // tail address = head + count - 1, head otherwise
      always_comb begin
         if (sel_tail_ff) begin
            rd_addr[g] = wrap({1'b0, head_ff[g]} + (AW+1)'(cnt_ff[g])
                              - (AW+1)'(1));
         end else begin
            rd_addr[g] = head_in[g];
         end
         wr_addr[g] = wrap({1'b0, head_ff[g]} + (AW+1)'(cnt_ff[g]));
      end
   end

   logic        is_push, strm, full;
   logic [31:0] vspan, aspan, span;
   logic [31:0] stamp_v, stamp_a, stamp_h;
   logic [EW-1:0] hd;
   logic        strm_d;

   always_comb begin
      is_push = (q_word.req_type == jbpr_pkg::REQ_PUSH_VIDEO)
             || (q_word.req_type == jbpr_pkg::REQ_PUSH_AUDIO);
      strm    = q_word.req_type[0];
      full    = (cnt_ff[strm] == CW'(QUEUE_DEPTH));
      stamp_v = first_ff[0][EW-1 -: 32];
      stamp_a = first_ff[1][EW-1 -: 32];
      vspan   = (cnt_ff[0] > CW'(1)) ? rd_data[0][EW-1 -: 32] - stamp_v : 32'd0;
      aspan   = (cnt_ff[1] > CW'(0)) ? rd_data[1][EW-1 -: 32] - stamp_a : 32'd0;
      span    = ($signed(aspan) > $signed(vspan)) ? aspan : vspan;
      strm_d  = (state_ff == jbpr_pkg::BK_DRAIN_A);
      hd      = rd_data[strm_d];
      stamp_h = hd[EW-1 -: 32];
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      cnt_in        = cnt_ff;
      play_in       = play_ff;
      org_data_in   = org_data_ff;
      org_sys_in    = org_sys_ff;
      dtime_in      = dtime_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      thr_in        = thr_ff;
      first_in      = first_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      sel_tail_in   = 1'b0;
      q_pop         = 1'b0;
      wr_en[0]      = 1'b0;
      wr_en[1]      = 1'b0;
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         jbpr_pkg::BK_IDLE: begin
            // hold until the result slot is free
            if (q_valid && !out_valid_in) begin
               out_in = '0;
               out_in.last = 1'b1;
               out_in.status = jbpr_pkg::ST_NONE;
               if (is_push) begin
                  q_pop = 1'b1;
                  out_in.out_stream = strm;
                  if (full) begin
                     out_in.status = jbpr_pkg::ST_DROPPED;
                  end else begin
                     out_in.status = jbpr_pkg::ST_ACCEPTED;
                     wr_en[strm] = 1'b1;
                     cnt_in[strm] = cnt_ff[strm] + CW'(1);
                  end
                  out_in.playing = play_ff;
                  out_valid_in = 1'b1;
               end else if (q_word.req_type == jbpr_pkg::REQ_TICK) begin
                  // read heads now, tails next
                  thr_in = 32'(auto_mode ? min_cache_seconds : cache_seconds)
                           * 32'(jbpr_pkg::MsPerSec);
                  dtime_in = org_data_ff + (q_word.now_ms - org_sys_ff);
                  hold_valid_in = 1'b0;
                  sel_tail_in = !play_ff;
                  if (play_ff && cnt_ff[0] == '0 && cnt_ff[1] == '0) begin
                     play_in = 1'b0;
                  end
                  state_in = play_ff ? jbpr_pkg::BK_DRAIN_V : jbpr_pkg::BK_READ;
               end else begin
                  q_pop = 1'b1;
                  out_in.playing = play_ff;
                  out_valid_in = 1'b1;
               end
            end
         end
         jbpr_pkg::BK_READ: begin
            // head data arrives; tail read in flight
            first_in[0] = rd_data[0];
            first_in[1] = rd_data[1];
            state_in = jbpr_pkg::BK_CACHE;
         end
         jbpr_pkg::BK_CACHE: begin
            // result slot is free here: the tick was only started with it empty
            q_pop = 1'b1;
            if ($signed(span) >= $signed(thr_ff)) begin
               play_in = 1'b1;
               org_sys_in = q_word.now_ms;
               if (cnt_ff[1] != '0 && stamp_a != 32'd0) begin
                  org_data_in = stamp_a;
               end else if (cnt_ff[0] > CW'(1)) begin
                  org_data_in = stamp_v;
               end else begin
                  org_data_in = 32'd0;
               end
            end
            out_in = '0;
            out_in.status = jbpr_pkg::ST_NONE;
            out_in.playing = play_in;
            out_in.last = 1'b1;
            out_valid_in = 1'b1;
            state_in = jbpr_pkg::BK_IDLE;
         end
         jbpr_pkg::BK_DRAIN_V, jbpr_pkg::BK_DRAIN_A: begin
            if (cnt_ff[strm_d] != '0 && stamp_h <= dtime_ff) begin
               // park the due head; send the one parked before when the slot is free
               if (!hold_valid_ff || !out_valid_in) begin
                  if (hold_valid_ff) begin
                     out_in = hold_ff;
                     out_valid_in = 1'b1;
                  end
                  hold_in = '0;
                  hold_in.status = jbpr_pkg::ST_RELEASED;
                  hold_in.out_stream = strm_d;
                  hold_in.out_kind = hd[39:32];
                  hold_in.out_handle = hd[31:16];
                  hold_in.out_length = hd[15:0];
                  hold_in.out_present_stamp = hd[71:40];
                  hold_in.playing = play_ff;
                  hold_valid_in = 1'b1;
                  head_in[strm_d] = wrap({1'b0, head_ff[strm_d]} + (AW+1)'(1));
                  cnt_in[strm_d] = cnt_ff[strm_d] - CW'(1);
               end
            end else if (!strm_d) begin
               state_in = jbpr_pkg::BK_DRAIN_A;
            end else if (!out_valid_in) begin
               // close the tick: the parked word, or an empty one, carries last
               q_pop = 1'b1;
               if (hold_valid_ff) begin
                  out_in = hold_ff;
               end else begin
                  out_in = '0;
                  out_in.status = jbpr_pkg::ST_NONE;
                  out_in.playing = play_ff;
               end
               out_in.last = 1'b1;
               out_valid_in = 1'b1;
               hold_valid_in = 1'b0;
               state_in = jbpr_pkg::BK_IDLE;
            end
         end
         default: state_in = jbpr_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= jbpr_pkg::BK_IDLE;
         head_ff[0]    <= '0;
         head_ff[1]    <= '0;
         cnt_ff[0]     <= '0;
         cnt_ff[1]     <= '0;
         play_ff       <= 1'b0;
         org_data_ff   <= 32'd0;
         org_sys_ff    <= 32'd0;
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         cnt_ff        <= cnt_in;
         play_ff       <= play_in;
         org_data_ff   <= org_data_in;
         org_sys_ff    <= org_sys_in;
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
      dtime_ff    <= dtime_in;
      thr_ff      <= thr_in;
      first_ff    <= first_in;
      sel_tail_ff <= sel_tail_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_ff;
endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the jitter buffer playout release block.
`timescale 1ns / 1ps

// Predicts the result words of the block and checks them as they arrive.
class playout_scoreboard;
   logic [31:0] stamp_mem [2][32];
   logic [31:0] present_mem [2][32];
   logic [39:0] tag_mem [2][32];
   int unsigned head [2];
   int unsigned count [2];
   bit          play_mode;
   logic [31:0] origin_data;
   logic [31:0] origin_sys;
   bit          auto_mode;
   logic [15:0] cache_sec;
   logic [15:0] min_sec;
   jbpr_pkg::rsp_word_type pending_words [$];
   int unsigned  error_count;

   function new();
      head = '{0, 0};
      count = '{0, 0};
      play_mode = 0;
      origin_data = '0;
      origin_sys = '0;
      auto_mode = 0;
      cache_sec = 16'd1;
      min_sec = 16'd1;
      error_count = 0;
   endfunction

   function void write_reg(jbpr_pkg::reg_index_type idx, logic [15:0] value);
      case (idx)
         jbpr_pkg::REG_AUTO_MODE: auto_mode = value[0];
         jbpr_pkg::REG_CACHE_SEC: cache_sec = value;
         jbpr_pkg::REG_MIN_SEC:   min_sec = value;
         default: ;
      endcase
   endfunction

   function void add_word(jbpr_pkg::status_type st, logic stream, logic [39:0] tag,
                          logic [31:0] pres, logic fin);
      jbpr_pkg::rsp_word_type r;
      r.status = st;
      r.out_stream = stream;
      r.out_kind = tag[39:32];
      r.out_handle = tag[31:16];
      r.out_length = tag[15:0];
      r.out_present_stamp = pres;
      r.playing = play_mode;
      r.last = fin;
      pending_words = {pending_words, r};
   endfunction

   function int span_of(int q);
      logic [31:0] d;
      d = stamp_mem[q][(head[q] + count[q] - 1) % 32] - stamp_mem[q][head[q]];
      return int'(d);
   endfunction

   // Work out every result word that one accepted request causes.
   function void note_request(jbpr_pkg::req_word_type w);
      int          q;
      int          vspan;
      int          aspan;
      int          span;
      int          threshold;
      int unsigned produced;
      logic [31:0] vfirst;
      logic [31:0] afirst;
      logic [31:0] decode_time;
      logic [15:0] secs;
      jbpr_pkg::req_code_type code;
      code = jbpr_pkg::req_code_type'(w.req_type);
      vspan = 0;
      aspan = 0;
      vfirst = '0;
      afirst = '0;
      produced = 0;
      case (code)
         jbpr_pkg::REQ_PUSH_VIDEO, jbpr_pkg::REQ_PUSH_AUDIO: begin
            q = (code == jbpr_pkg::REQ_PUSH_VIDEO) ? 0 : 1;
            if (count[q] >= 32) begin
               add_word(jbpr_pkg::ST_DROPPED, q[0], '0, '0, 1'b1);
            end else begin
               stamp_mem[q][(head[q] + count[q]) % 32] = w.decode_stamp;
               present_mem[q][(head[q] + count[q]) % 32] = w.present_stamp;
               tag_mem[q][(head[q] + count[q]) % 32] = {w.pkt_kind, w.pkt_handle, w.pkt_length};
               count[q]++;
               add_word(jbpr_pkg::ST_ACCEPTED, q[0], '0, '0, 1'b1);
            end
         end
         jbpr_pkg::REQ_TICK: begin
            if (!play_mode) begin
               secs = auto_mode ? min_sec : cache_sec;
               threshold = int'(secs) * int'(jbpr_pkg::MsPerSec);
               if (count[0] > 1) begin
                  vspan = span_of(0);
                  vfirst = stamp_mem[0][head[0]];
               end
               if (count[1] > 0) begin
                  aspan = span_of(1);
                  afirst = stamp_mem[1][head[1]];
               end
               span = (aspan > vspan) ? aspan : vspan;
               if (span >= threshold) begin
                  origin_sys = w.now_ms;
                  origin_data = (afirst != 0) ? afirst : vfirst;
                  play_mode = 1;
               end
               add_word(jbpr_pkg::ST_NONE, 1'b0, '0, '0, 1'b1);
            end else begin
               decode_time = origin_data + (w.now_ms - origin_sys);
               if (count[0] == 0 && count[1] == 0) play_mode = 0;
               // release all due video, then all due audio
               for (q = 0; q < 2; q++) begin
                  while (count[q] > 0 && stamp_mem[q][head[q]] <= decode_time) begin
                     add_word(jbpr_pkg::ST_RELEASED, q[0], tag_mem[q][head[q]],
                              present_mem[q][head[q]], 1'b0);
                     head[q] = (head[q] + 1) % 32;
                     count[q]--;
                     produced++;
                  end
               end
               if (produced == 0) add_word(jbpr_pkg::ST_NONE, 1'b0, '0, '0, 1'b1);
               else pending_words[pending_words.size() - 1].last = 1'b1;
            end
         end
         default: add_word(jbpr_pkg::ST_NONE, 1'b0, '0, '0, 1'b1);
      endcase
   endfunction

   function void check_word(jbpr_pkg::rsp_word_type got);
      jbpr_pkg::rsp_word_type want;
      if (pending_words.size() == 0) begin
         $error("result word with nothing expected: %p", got);
         error_count++;
         return;
      end
      want = pending_words[0];
      pending_words.delete(0);
      if (got.status !== want.status) begin
         $error("status expected %0d actual %0d", want.status, got.status);
         error_count++;
      end
      if (got.out_stream !== want.out_stream) begin
         $error("out_stream expected %0d actual %0d", want.out_stream, got.out_stream);
         error_count++;
      end
      if (got.out_kind !== want.out_kind) begin
         $error("out_kind expected %0h actual %0h", want.out_kind, got.out_kind);
         error_count++;
      end
      if (got.out_handle !== want.out_handle) begin
         $error("out_handle expected %0h actual %0h", want.out_handle, got.out_handle);
         error_count++;
      end
      if (got.out_length !== want.out_length) begin
         $error("out_length expected %0h actual %0h", want.out_length, got.out_length);
         error_count++;
      end
      if (got.out_present_stamp !== want.out_present_stamp) begin
         $error("out_present_stamp expected %0h actual %0h",
                want.out_present_stamp, got.out_present_stamp);
         error_count++;
      end
      if (got.playing !== want.playing) begin
         $error("playing expected %0d actual %0d", want.playing, got.playing);
         error_count++;
      end
      if (got.last !== want.last) begin
         $error("last expected %0d actual %0d", want.last, got.last);
         error_count++;
      end
   endfunction
endclass

module tb;
   localparam int unsigned IdleLimit = 4000;
   localparam int unsigned SettleCycles = 40;

   logic clock;
   logic reset;

   jbpr_req_if req_ch ();
   jbpr_rsp_if rsp_ch ();
   jbpr_csr_if csr_ch ();

   jitter_buffer_playout_release i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   playout_scoreboard board = new();

   // sender burst shaping
   int unsigned burst_left = 0;
   // receiver hold-off requested by the stimulus, in cycles
   int unsigned hold_request = 0;
   int unsigned hold_left = 0;
   int unsigned pattern_left = 0;
   int unsigned pattern_mode = 0;
   int unsigned idle_cycles = 0;

   // media clocks that keep the random stream well formed
   logic [31:0] video_dts;
   logic [31:0] audio_dts;
   logic [31:0] sys_now;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = jbpr_pkg::REG_NONE;
      csr_ch.wdata = '0;
   end

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: check accepted words, then pick the next ready level.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) board.check_word(rsp_ch.data);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(8, 80);
            pattern_mode = $urandom_range(0, 2);
         end
         pattern_left--;
         if (hold_left != 0) begin
            // long hold-off: let the block back up into its input
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (pattern_mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 9) < 6);
               default: rsp_ch.ready <= ($urandom_range(0, 2) == 0);
            endcase
         end
      end
   end

   // Watchdog: count cycles in which no channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("[jitter_buffer_playout_release] ERROR");
            $finish;
         end
      end
   end

   // Offer one request word; hold it until accepted, then note it.
   task automatic send_req(jbpr_pkg::req_word_type w);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.data <= w;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(w);
   endtask

   // Drop valid and wait until every expected word is back, then settle.
   task automatic drain_all();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(jbpr_pkg::reg_index_type idx, logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= value;
      do @(posedge clock); while (!csr_ch.ready);
      board.write_reg(idx, value);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(logic auto_bit, logic [15:0] cache_val, logic [15:0] min_val);
      write_csr(jbpr_pkg::REG_AUTO_MODE, {15'd0, auto_bit});
      write_csr(jbpr_pkg::REG_CACHE_SEC, cache_val);
      write_csr(jbpr_pkg::REG_MIN_SEC, min_val);
   endtask

   function automatic jbpr_pkg::req_word_type make_req(jbpr_pkg::req_code_type code,
                                                       logic [31:0] dts,
                                                       logic [31:0] pts,
                                                       logic [31:0] now);
      jbpr_pkg::req_word_type w;
      w.req_type = code;
      w.pkt_kind = 8'($urandom);
      w.pkt_handle = 16'($urandom);
      w.pkt_length = 16'($urandom);
      w.decode_stamp = dts;
      w.present_stamp = pts;
      w.now_ms = now;
      return w;
   endfunction

   // Mostly a plausible media stream; some noise with arbitrary fields.
   function automatic jbpr_pkg::req_word_type random_req();
      jbpr_pkg::req_word_type w;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         w = make_req(jbpr_pkg::req_code_type'($urandom_range(0, 3)),
                      $urandom, $urandom, $urandom);
      end else if (pick < 48) begin
         video_dts = video_dts + $urandom_range(20, 60);
         w = make_req(jbpr_pkg::REQ_PUSH_VIDEO, video_dts,
                      video_dts + $urandom_range(0, 100), '0);
      end else if (pick < 80) begin
         audio_dts = audio_dts + $urandom_range(15, 40);
         w = make_req(jbpr_pkg::REQ_PUSH_AUDIO, audio_dts,
                      audio_dts + $urandom_range(0, 10), '0);
      end else if (pick < 97) begin
         sys_now = sys_now + $urandom_range(0, 150);
         w = make_req(jbpr_pkg::REQ_TICK, $urandom, $urandom, sys_now);
      end else begin
         w = make_req(jbpr_pkg::REQ_UNUSED, $urandom, $urandom, $urandom);
      end
      return w;
   endfunction

   task automatic random_phase(int unsigned n);
      repeat (n) send_req(random_req());
   endtask

   initial begin
      jbpr_pkg::req_word_type w;
      video_dts = $urandom;
      audio_dts = video_dts;
      sys_now = $urandom;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default thresholds, field extremes and every request code
      set_regs(1'b0, 16'd1, 16'd1);
      w = make_req(jbpr_pkg::REQ_PUSH_VIDEO, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      w.pkt_kind = 8'hFF;
      w.pkt_handle = 16'hFFFF;
      w.pkt_length = 16'hFFFF;
      send_req(w);
      w = make_req(jbpr_pkg::REQ_PUSH_VIDEO, 32'd400, 32'd0, 32'd0);
      w.pkt_kind = 8'h00;
      w.pkt_handle = 16'h0000;
      w.pkt_length = 16'h0000;
      send_req(w);
      send_req(make_req(jbpr_pkg::REQ_PUSH_AUDIO, 32'd0, 32'd5, 32'd0));
      // caching tick below threshold
      send_req(make_req(jbpr_pkg::REQ_TICK, 32'd0, 32'd0, 32'd100));
      send_req(make_req(jbpr_pkg::REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF));
      // audio span reaches one second; first audio stamp zero, so video origin
      send_req(make_req(jbpr_pkg::REQ_PUSH_AUDIO, 32'd1000, 32'd1001, 32'd0));
      send_req(make_req(jbpr_pkg::REQ_TICK, 32'd0, 32'd0, 32'hFFFF_FFF0));
      // time wraps; release part of the queues, then everything
      send_req(make_req(jbpr_pkg::REQ_TICK, 32'd0, 32'd0, 32'h0000_0100));
      send_req(make_req(jbpr_pkg::REQ_TICK, 32'd0, 32'd0, 32'h0000_0800));
      // both empty at a playing tick: back to caching
      send_req(make_req(jbpr_pkg::REQ_TICK, 32'd0, 32'd0, 32'h0000_0900));
      send_req(make_req(jbpr_pkg::REQ_TICK, 32'd0, 32'd0, 32'h0000_0A00));
      // wrapped span reads negative
      send_req(make_req(jbpr_pkg::REQ_PUSH_VIDEO, 32'hFFFF_FF00, 32'd1, 32'd0));
      send_req(make_req(jbpr_pkg::REQ_PUSH_VIDEO, 32'h7FFF_FFFF, 32'd2, 32'd0));
      send_req(make_req(jbpr_pkg::REQ_TICK, 32'd0, 32'd0, 32'd7));
      drain_all();

      // auto mode with zero threshold: playback starts at once
      set_regs(1'b1, 16'hFFFF, 16'd0);
      send_req(make_req(jbpr_pkg::REQ_TICK, 32'd0, 32'd0, sys_now));
      random_phase(40);
      drain_all();

      // huge threshold: caching holds, queues fill and drop under a long stall
      set_regs(1'b0, 16'hFFFF, 16'd3);
      hold_request = 400;
      repeat (40) begin
         video_dts = video_dts + 33;
         send_req(make_req(jbpr_pkg::REQ_PUSH_VIDEO, video_dts, video_dts, '0));
      end
      random_phase(20);
      drain_all();

      // normal mode, zero cache threshold releases the full queues
      set_regs(1'b0, 16'd0, 16'hFFFF);
      send_req(make_req(jbpr_pkg::REQ_TICK, 32'd0, 32'd0, sys_now));
      sys_now = sys_now + 32'd100000;
      send_req(make_req(jbpr_pkg::REQ_TICK, 32'd0, 32'd0, sys_now));
      random_phase(30);
      drain_all();

      // auto mode, maximal minimum threshold, then two seconds normal
      set_regs(1'b1, 16'd2, 16'hFFFF);
      random_phase(15);
      drain_all();
      set_regs(1'b0, 16'd2, 16'd1);
      random_phase(25);

      drain_all();
      if (board.error_count == 0) begin
         $display("[jitter_buffer_playout_release] OK");
      end else begin
         $display("[jitter_buffer_playout_release] ERROR");
      end
      $finish;
   end
endmodule
